>>> rtl/adc_to_dds_tuning_word_defines.svh
// assertion macros for the tuning word rtl
`ifndef ADC_TO_DDS_TUNING_WORD_DEFINES_SVH
`define ADC_TO_DDS_TUNING_WORD_DEFINES_SVH

// same-cycle implication, skipped while reset is high
`define ADTW_ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("adtw check failed");

// next-cycle implication, also checked across reset
`define ADTW_ASSERT_NEXT(label, clk, cond, expr) \
  label: assert property (@(posedge clk) (cond) |=> (expr)) \
    else $error("adtw check failed");

`endif

>>> rtl/adtw_pkg.sv
// shared widths, constants and payload types of the tuning word block
package adtw_pkg;

  // field widths
  localparam int READING_W = 10;
  localparam int REFCLK_W  = 16;
  localparam int FREQ_W    = 14;
  localparam int WORD_W    = 16;
  localparam int QUOT_W    = FREQ_W + WORD_W;

  localparam int NUM_OSCILLATORS = 2;
  localparam int REFCLK_RESET    = 3906;
  localparam int FREQ_MAX        = 15257;

  // piecewise map: segment 0 starts at 0, each later segment k at 93*(k+1)
  localparam int SEG_STEP    = 93;
  localparam int SEG_LAST    = 9;
  localparam int SEG_W       = 4;
  localparam int DIFF_W      = 8;
  localparam int MULT_W      = 14;
  localparam int PROD_W      = 22;
  localparam int BASE_MULT   = 30;
  localparam int LAST_OFFSET = 838;
  localparam int LAST_MULT   = 16000;

  // constant divisors and their reciprocals
  localparam int DIV_MAIN    = 186;
  localparam int DIV_LAST    = 194;
  localparam int DIVC_W      = 9;
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = 15;
  localparam int RECIP_MAIN  = (1 << RECIP_SHIFT) / DIV_MAIN;
  localparam int RECIP_LAST  = (1 << RECIP_SHIFT) / DIV_LAST;

  // long division: quotient bits resolved per stage
  localparam int DIV_STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES          = QUOT_W / DIV_STEPS_PER_STAGE;

  typedef struct packed {
    logic [READING_W-1:0] control_reading;
    logic                 oscillator_select;
  } reading_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              osc;
  } freq_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] tuning_word;
    logic [FREQ_W-1:0] note_frequency;
    logic              oscillator_out;
    logic              word_overflow;
  } word_item_t;

endpackage

>>> rtl/adtw_if.sv
// valid/ready channels for readings in and tuning words out
interface adtw_reading_if import adtw_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [READING_W-1:0] control_reading;
  logic                 oscillator_select;

  modport source(output valid, output control_reading, output oscillator_select,
                 input ready);
  modport sink(input valid, input control_reading, input oscillator_select,
               output ready);
endinterface

interface adtw_word_if import adtw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] tuning_word;
  logic [FREQ_W-1:0] note_frequency;
  logic              oscillator_out;
  logic              word_overflow;

  modport source(output valid, output tuning_word, output note_frequency,
                 output oscillator_out, output word_overflow, input ready);
  modport sink(input valid, input tuning_word, input note_frequency,
               input oscillator_out, input word_overflow, output ready);
endinterface

>>> rtl/adtw_freq_map.sv
// four-stage piecewise-linear map from control reading to frequency
module adtw_freq_map import adtw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  reading_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output freq_item_t out_item
);

  typedef struct packed {
    logic [DIFF_W-1:0] diff;
    logic [SEG_W-1:0]  seg;
    logic              last;
    logic              osc;
  } s1_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic              last;
    logic              osc;
  } s2_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [FREQ_W-1:0] q_est;
    logic              last;
    logic              osc;
  } s3_t;

  logic       v1, v2, v3, v4;
  logic       en1, en2, en3, en4;
  s1_t        s1, s1_next;
  s2_t        s2, s2_next;
  s3_t        s3, s3_next;
  freq_item_t s4, s4_next;

  logic [SEG_W-1:0]     seg;
  logic [READING_W-1:0] offset;
  logic [MULT_W-1:0]    mult;
  logic [RECIP_W-1:0]   recip;
  logic [PROD_W+RECIP_W-1:0] scaled;
  logic [DIVC_W-1:0]    divc;
  logic [PROD_W-1:0]    back;
  logic [PROD_W-1:0]    rem_full;
  logic [DIVC_W-1:0]    rem;

  // stage advances when empty or when its successor advances
  assign en4      = !v4 || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // stage 1: find the segment and the offset into it
  always_comb begin
    seg = SEG_W'(SEG_LAST);
    for (int k = SEG_LAST - 1; k >= 0; k--) begin
      if (in_item.control_reading < READING_W'(SEG_STEP * (k + 2))) begin
        seg = SEG_W'(k);
      end
    end
    if (seg == SEG_W'(SEG_LAST)) begin
      offset = READING_W'(LAST_OFFSET);
    end else begin
      offset = READING_W'(seg) * READING_W'(SEG_STEP);
    end
    s1_next.diff = DIFF_W'(in_item.control_reading - offset);
    s1_next.seg  = seg;
    s1_next.last = (seg == SEG_W'(SEG_LAST));
    s1_next.osc  = in_item.oscillator_select;
  end

  // stage 2: scale by the segment slope
  always_comb begin
    if (s1.last) begin
      mult = MULT_W'(LAST_MULT);
    end else begin
      mult = MULT_W'(BASE_MULT) << s1.seg;
    end
    s2_next.prod = PROD_W'(s1.diff) * PROD_W'(mult);
    s2_next.last = s1.last;
    s2_next.osc  = s1.osc;
  end

  // stage 3: quotient estimate by reciprocal, low by at most one
  always_comb begin
    recip  = s2.last ? RECIP_W'(RECIP_LAST) : RECIP_W'(RECIP_MAIN);
    scaled = (PROD_W + RECIP_W)'(s2.prod) * (PROD_W + RECIP_W)'(recip);
    s3_next.prod  = s2.prod;
    s3_next.q_est = scaled[RECIP_SHIFT +: FREQ_W];
    s3_next.last  = s2.last;
    s3_next.osc   = s2.osc;
  end

  // stage 4: remainder check corrects the estimate
  always_comb begin
    divc     = s3.last ? DIVC_W'(DIV_LAST) : DIVC_W'(DIV_MAIN);
    back     = PROD_W'(s3.q_est) * PROD_W'(divc);
    rem_full = s3.prod - back;
    rem      = rem_full[DIVC_W-1:0];
    s4_next.freq = s3.q_est + FREQ_W'(rem >= divc);
    s4_next.osc  = s3.osc;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
    if (en4) s4 <= s4_next;
  end

  assign out_valid = v4;
  assign out_item  = s4;

endmodule

>>> rtl/adtw_divider.sv
// pipelined restoring divider: (freq << 16) / reference clock
module adtw_divider import adtw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  freq_item_t          in_item,
  input  logic [REFCLK_W-1:0] divisor,
  output logic                out_valid,
  input  logic                out_ready,
  output word_item_t          out_item
);

  typedef struct packed {
    logic [REFCLK_W-1:0] rem;
    logic [QUOT_W-1:0]   quot;
    logic [FREQ_W-1:0]   dvd;
    logic [FREQ_W-1:0]   freq;
    logic                osc;
  } div_stage_t;

  div_stage_t            st [DIV_STAGES];
  logic [DIV_STAGES-1:0] v;
  logic [DIV_STAGES-1:0] en;
  div_stage_t            init;

  // dividend high bits come from freq; the low sixteen are zero
  always_comb begin
    init.rem  = '0;
    init.quot = '0;
    init.dvd  = in_item.freq;
    init.freq = in_item.freq;
    init.osc  = in_item.osc;
  end

  assign en[DIV_STAGES-1] = !v[DIV_STAGES-1] || out_ready;
  assign in_ready         = en[0];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    div_stage_t       prev;
    div_stage_t       nxt;
    logic [REFCLK_W:0] trial;

    if (k == 0) begin : g_first
      assign prev = init;
    end else begin : g_rest
      assign prev = st[k-1];
      assign en[k-1] = !v[k-1] || en[k];
    end

    // three quotient bits per stage, msb first
    always_comb begin
      nxt   = prev;
      trial = '0;
      for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
        trial   = {nxt.rem, nxt.dvd[FREQ_W-1]};
        nxt.dvd = {nxt.dvd[FREQ_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          trial    = trial - {1'b0, divisor};
          nxt.quot = {nxt.quot[QUOT_W-2:0], 1'b1};
        end else begin
          nxt.quot = {nxt.quot[QUOT_W-2:0], 1'b0};
        end
        nxt.rem = trial[REFCLK_W-1:0];
      end
    end

    // valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k - 1];
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k] <= nxt;
      end
    end
  end

  // last stage is the output register
  assign out_valid               = v[DIV_STAGES-1];
  assign out_item.tuning_word    = st[DIV_STAGES-1].quot[WORD_W-1:0];
  assign out_item.note_frequency = st[DIV_STAGES-1].freq;
  assign out_item.oscillator_out = st[DIV_STAGES-1].osc;
  assign out_item.word_overflow  = |st[DIV_STAGES-1].quot[QUOT_W-1:WORD_W];

endmodule

>>> rtl/adc_to_dds_tuning_word.sv
// Converts a 10-bit control reading into a phase-increment word for a
// phase-accumulator oscillator: the reading maps to a note frequency in Hz
// over ten linear segments, then the word is the low 16 bits of
// 65536*frequency/reference_clock, with word_overflow set when the full
// quotient does not fit (and all ones when reference_clock is zero). One
// reading is taken every cycle while the output is not held; each result
// passes four stages of frequency mapping (segment select, slope multiply,
// reciprocal multiply, remainder correction) and ten stages of restoring
// division resolving three quotient bits each. Readings for an oscillator
// number at or above the configured count are taken and produce no result.
// reference_clock resets to 3906; the user must write it only while no
// transaction is in flight, as the block itself does not enforce this.
`include "adc_to_dds_tuning_word_defines.svh"

module adc_to_dds_tuning_word import adtw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                reference_clock_we,
  input  logic [REFCLK_W-1:0] reference_clock_wdata,
  adtw_reading_if.sink        reading,
  adtw_word_if.source         word
);

  logic [REFCLK_W-1:0] reference_clock;
  logic                osc_ok;
  reading_t            fm_in;
  logic                fm_valid;
  logic                fm_ready;
  freq_item_t          fm_out;
  word_item_t          dv_out;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_clock <= REFCLK_W'(REFCLK_RESET);
    end else if (reference_clock_we) begin
      reference_clock <= reference_clock_wdata;
    end
  end

  // out-of-range oscillator numbers are consumed without a result
  assign osc_ok = {31'b0, reading.oscillator_select} < 32'(NUM_OSCILLATORS);

  assign fm_in.control_reading   = reading.control_reading;
  assign fm_in.oscillator_select = reading.oscillator_select;

  adtw_freq_map u_freq_map (
    .clk      (clk),
    .rst      (rst),
    .in_valid (reading.valid && osc_ok),
    .in_ready (reading.ready),
    .in_item  (fm_in),
    .out_valid(fm_valid),
    .out_ready(fm_ready),
    .out_item (fm_out)
  );

  adtw_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fm_valid),
    .in_ready (fm_ready),
    .in_item  (fm_out),
    .divisor  (reference_clock),
    .out_valid(word.valid),
    .out_ready(word.ready),
    .out_item (dv_out)
  );

  assign word.tuning_word    = dv_out.tuning_word;
  assign word.note_frequency = dv_out.note_frequency;
  assign word.oscillator_out = dv_out.oscillator_out;
  assign word.word_overflow  = dv_out.word_overflow;

  // overflow flag agrees with frequency against the divisor
  `ADTW_ASSERT_IMPLY(a_ovf_rule, clk, rst, word.valid, word.word_overflow == (word.note_frequency >= reference_clock))

  // an in-range word never exceeds the true quotient
  `ADTW_ASSERT_IMPLY(a_word_bound, clk, rst, word.valid && !word.word_overflow, ({16'b0, word.tuning_word} * {16'b0, reference_clock}) <= {2'b0, word.note_frequency, 16'b0})

  // mapped frequency stays within the top segment's reach
  `ADTW_ASSERT_IMPLY(a_freq_max, clk, rst, word.valid, word.note_frequency <= FREQ_W'(FREQ_MAX))

  // input backpressure only when the output register is held
  `ADTW_ASSERT_IMPLY(a_stall_src, clk, rst, !reading.ready, word.valid && !word.ready)

  // reset empties the pipeline
  `ADTW_ASSERT_NEXT(a_reset_empty, clk, rst, !word.valid && reading.ready)

endmodule

>>> sim/adc_to_dds_tuning_word_test.sv
// testbench for the control reading to tuning word converter
`timescale 1ns / 1ps

module adc_to_dds_tuning_word_test import adtw_pkg::*;;

  // one row of the directed stimulus; want_* is used only where typed is set
  typedef struct packed {
    logic                load_refclk;
    logic [REFCLK_W-1:0] refclk_value;
    logic [READING_W-1:0] reading;
    logic                osc;
    logic                typed;
    logic [WORD_W-1:0]   want_word;
    logic [FREQ_W-1:0]   want_freq;
    logic                want_ovf;
  } directed_row_t;

  localparam int DIRECTED_N = 20;
  localparam int PHASE_ITEMS = 155;
  localparam int SETTLE_CYCLES = 20;

  localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    // after reset: lowest and highest reading
    '{1'b0, 16'd0, 10'd0, 1'b0, 1'b1, 16'd0, 14'd0, 1'b0},
    '{1'b0, 16'd0, 10'd1023, 1'b1, 1'b1, 16'd59378, 14'd15257, 1'b1},
    // segment edges
    '{1'b0, 16'd0, 10'd92, 1'b0, 1'b0, 16'd0, 14'd0, 1'b0},
    '{1'b0, 16'd0, 10'd93, 1'b1, 1'b0, 16'd0, 14'd0, 1'b0},
    '{1'b0, 16'd0, 10'd185, 1'b0, 1'b0, 16'd0, 14'd0, 1'b0},
    '{1'b0, 16'd0, 10'd186, 1'b1, 1'b0, 16'd0, 14'd0, 1'b0},
    '{1'b0, 16'd0, 10'd464, 1'b0, 1'b0, 16'd0, 14'd0, 1'b0},
    '{1'b0, 16'd0, 10'd465, 1'b1, 1'b0, 16'd0, 14'd0, 1'b0},
    '{1'b0, 16'd0, 10'd836, 1'b0, 1'b0, 16'd0, 14'd0, 1'b0},
    '{1'b0, 16'd0, 10'd837, 1'b1, 1'b0, 16'd0, 14'd0, 1'b0},
    '{1'b0, 16'd0, 10'd929, 1'b0, 1'b0, 16'd0, 14'd0, 1'b0},
    '{1'b0, 16'd0, 10'd930, 1'b1, 1'b0, 16'd0, 14'd0, 1'b0},
    // alternating bit patterns
    '{1'b0, 16'd0, 10'h2aa, 1'b0, 1'b0, 16'd0, 14'd0, 1'b0},
    '{1'b0, 16'd0, 10'h155, 1'b1, 1'b0, 16'd0, 14'd0, 1'b0},
    // zero reference clock: word saturates to all ones
    '{1'b1, 16'd0, 10'd0, 1'b0, 1'b1, 16'hffff, 14'd0, 1'b1},
    '{1'b0, 16'd0, 10'd1023, 1'b1, 1'b1, 16'hffff, 14'd15257, 1'b1},
    // divide by one: word is the frequency shifted up, always wraps unless zero
    '{1'b1, 16'd1, 10'd0, 1'b1, 1'b1, 16'd0, 14'd0, 1'b0},
    '{1'b0, 16'd0, 10'd1023, 1'b0, 1'b1, 16'd0, 14'd15257, 1'b1},
    // largest divisor
    '{1'b1, 16'hffff, 10'd1023, 1'b1, 1'b1, 16'd15257, 14'd15257, 1'b0},
    '{1'b0, 16'd0, 10'd500, 1'b0, 1'b0, 16'd0, 14'd0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_we = 1'b0;
  logic [REFCLK_W-1:0]  cfg_wdata = '0;
  logic                 src_valid = 1'b0;
  logic [READING_W-1:0] src_reading = '0;
  logic                 src_osc = 1'b0;
  logic                 sink_ready = 1'b0;

  // expectation attached to the reading currently offered
  logic       drive_typed = 1'b0;
  word_item_t drive_want = '0;

  logic [REFCLK_W-1:0] refclk_shadow = REFCLK_W'(REFCLK_RESET);
  word_item_t          words_due[$];
  int                  send_idle = 0;
  int                  recv_idle = 0;
  int                  errors = 0;

  adtw_reading_if reading_ch ();
  adtw_word_if    word_ch ();

  assign reading_ch.valid             = src_valid;
  assign reading_ch.control_reading   = src_reading;
  assign reading_ch.oscillator_select = src_osc;
  assign word_ch.ready                = sink_ready;

  adc_to_dds_tuning_word dut (
    .clk                   (clk),
    .rst                   (rst),
    .reference_clock_we    (cfg_we),
    .reference_clock_wdata (cfg_wdata),
    .reading               (reading_ch),
    .word                  (word_ch)
  );

  always #10 clk = ~clk;

  // piecewise map from reading to note frequency in Hz
  function automatic logic [FREQ_W-1:0] map_note_frequency(input logic [READING_W-1:0] x);
    int unsigned v;
    int unsigned seg;
    v = x;
    if (v < 93) return FREQ_W'((v * 15) / 93);
    if (v < 186) return FREQ_W'((v * 30) / 186);
    if (v < 930) begin
      // segments 2..9 start one segment late and double the slope each time
      seg = v / 93;
      return FREQ_W'(((v - (seg - 1) * 93) * (30 << (seg - 1))) / 186);
    end
    return FREQ_W'(((v - 838) * 16000) / 194);
  endfunction

  // expected tuning word for one reading under the given reference clock
  function automatic word_item_t predict_tuning_word(input logic [READING_W-1:0] x,
                                                     input logic osc,
                                                     input logic [REFCLK_W-1:0] refclk);
    word_item_t       w;
    longint unsigned  num;
    longint unsigned  quot;
    w.note_frequency = map_note_frequency(x);
    w.oscillator_out = osc;
    if (refclk == '0) begin
      w.tuning_word   = '1;
      w.word_overflow = 1'b1;
    end else begin
      num             = longint'(w.note_frequency) << 16;
      quot            = num / refclk;
      w.tuning_word   = WORD_W'(quot);
      w.word_overflow = (quot > 64'hffff);
    end
    return w;
  endfunction

  // random reading, with a share clustered on the segment edges
  function automatic logic [READING_W-1:0] pick_reading();
    int v;
    if ($urandom_range(3) == 0) begin
      v = 93 * $urandom_range(10) + $urandom_range(2) - 1;
      if (v < 0) v = 0;
    end else begin
      v = $urandom_range(1023);
    end
    return READING_W'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // offer one reading, with random idle cycles first; returns at a falling edge
  task automatic send_reading(input logic [READING_W-1:0] x, input logic osc,
                              input logic typed, input word_item_t want);
    while ($urandom_range(99) < send_idle) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid   <= 1'b1;
    src_reading <= x;
    src_osc     <= osc;
    drive_typed <= typed;
    drive_want  <= want;
    do @(posedge clk); while (!(src_valid && reading_ch.ready));
    @(negedge clk);
  endtask

  // hold off the sender until every expected word has come back
  task automatic drain_words();
    src_valid <= 1'b0;
    do @(negedge clk); while (words_due.size() != 0);
  endtask

  task automatic write_refclk(input logic [REFCLK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we        <= 1'b0;
    refclk_shadow  = value;
    @(negedge clk);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    sink_ready <= ($urandom_range(99) >= recv_idle);
  end

  // record accepted readings and check accepted words
  always @(posedge clk) begin
    word_item_t due;
    word_item_t want;
    if (!rst) begin
      if (src_valid && reading_ch.ready && src_osc < NUM_OSCILLATORS) begin
        if (drive_typed) begin
          want                = drive_want;
          want.oscillator_out = src_osc;
        end else begin
          want = predict_tuning_word(src_reading, src_osc, refclk_shadow);
        end
        words_due.push_back(want);
      end
      if (word_ch.valid && sink_ready) begin
        if (words_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d", word_ch.tuning_word));
        end else begin
          due = words_due.pop_front();
          if (word_ch.tuning_word !== due.tuning_word)
            report_mismatch($sformatf("tuning_word got %0d want %0d",
                                      word_ch.tuning_word, due.tuning_word));
          if (word_ch.note_frequency !== due.note_frequency)
            report_mismatch($sformatf("note_frequency got %0d want %0d",
                                      word_ch.note_frequency, due.note_frequency));
          if (word_ch.oscillator_out !== due.oscillator_out)
            report_mismatch($sformatf("oscillator_out got %0d want %0d",
                                      word_ch.oscillator_out, due.oscillator_out));
          if (word_ch.word_overflow !== due.word_overflow)
            report_mismatch($sformatf("word_overflow got %0d want %0d",
                                      word_ch.word_overflow, due.word_overflow));
        end
      end
    end
  end

  // main stimulus
  initial begin
    directed_row_t  row;
    word_item_t     want;
    logic [REFCLK_W-1:0] refclk;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed table, sender idles often and receiver more
    send_idle = 34;
    recv_idle = 85;
    for (int i = 0; i < DIRECTED_N; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.load_refclk) begin
        drain_words();
        write_refclk(row.refclk_value);
      end
      want.tuning_word    = row.want_word;
      want.note_frequency = row.want_freq;
      want.oscillator_out = row.osc;
      want.word_overflow  = row.want_ovf;
      send_reading(row.reading, row.osc, row.typed, want);
    end

    // random phases, two reference clock settings per idling pattern
    for (int ph = 0; ph < 6; ph++) begin
      drain_words();
      case (ph / 2)
        0: begin
          send_idle = 34;
          recv_idle = 85;
        end
        1: begin
          send_idle = 85;
          recv_idle = 34;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      case (ph)
        0: refclk = REFCLK_W'($urandom_range(65535, 1));
        1: refclk = 16'd1;
        2: refclk = 16'hffff;
        3: refclk = 16'd0;
        4: refclk = REFCLK_W'($urandom_range(4000, 1));
        default: refclk = REFCLK_W'($urandom);
      endcase
      write_refclk(refclk);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(199) == 0) drain_words();
        send_reading(pick_reading(), 1'($urandom_range(1)), 1'b0, '0);
      end
    end

    drain_words();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
